>>> src/gqbp_pkg.sv
// Shared types and constants for the grey-level quantiser and bit packer.
// No dependencies; imported by gqbp_pack and grey_quantize_bit_packer.
package gqbp_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned BitsW   = 3;
  localparam int unsigned CodeW   = 7;
  localparam int unsigned AccW    = 7;
  localparam int unsigned CombW   = AccW + CodeW;
  localparam int unsigned TotW    = 4;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW    = 2;
  localparam int unsigned CntW    = 3;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [AddrW-1:0] RegBitsPerPixel = 3'd0;
  localparam logic [BitsW-1:0] BitsReset       = 3'd1;

  // Rounding bias (255/2, floored) applied to p*(2^b-1) before dividing by 255
  localparam logic [14:0] QuantHalfBias = 15'd127;

  typedef struct packed {
    logic            last;
    logic [PixW-1:0] data;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       n_items;
    out_item_t        item0;
    out_item_t        item1;
    logic [AccW-1:0]  acc_nxt;
    logic [BitsW-1:0] pend_nxt;
  } pack_res_t;

endpackage

>>> src/gqbp_pack.sv
// Quantises one pixel to the configured code width and merges the code into
// the bit accumulator, giving up to two output bytes. Depends on gqbp_pkg.
module gqbp_pack import gqbp_pkg::*; (
  input  logic [PixW-1:0]  pixel_i,
  input  logic             last_pixel_i,
  input  logic [BitsW-1:0] bits_i,
  input  logic [AccW-1:0]  acc_i,
  input  logic [BitsW-1:0] pend_i,
  output pack_res_t        res_o
);

  logic [14:0]       num;
  logic [15:0]       div_sum;
  logic [CodeW-1:0]  code;
  logic [CombW-1:0]  comb;
  logic [CombW-1:0]  comb_rem;
  logic [CombW-1:0]  shifted;
  logic [CombW-1:0]  rem_mask;
  logic [TotW-1:0]   total;
  logic              full;
  logic [BitsW-1:0]  rem;
  logic [BitsW-1:0]  left;
  logic [PixW-1:0]   flush_byte;
  logic              flush;

  always_comb begin
    // floor((2*p*(Z-1)+255)/510) == floor((p*(Z-1)+127)/255)
    num = (15'({7'd0, pixel_i}) << bits_i) - 15'({7'd0, pixel_i}) + QuantHalfBias;
    // divide by 255 for values below 65535
    div_sum = {1'b0, num} + 16'd1 + {8'd0, num[14:8]};
    code = div_sum[14:8];

    comb  = (CombW'({7'd0, acc_i}) << bits_i) | {7'd0, code};
    total = {1'b0, pend_i} + {1'b0, bits_i};
    full  = total[3];
    rem   = total[2:0];

    shifted  = comb >> rem;
    rem_mask = (14'd1 << rem) - 14'd1;
    if (full) begin
      comb_rem = comb & rem_mask;
    end else begin
      comb_rem = comb;
    end
    left = rem;

    flush      = last_pixel_i && (left != 3'd0);
    flush_byte = comb_rem[PixW-1:0] << (4'd8 - {1'b0, left});

    res_o = '0;
    if (full) begin
      res_o.item0.data = shifted[PixW-1:0];
      res_o.item0.last = last_pixel_i && (left == 3'd0);
      res_o.item1.data = flush_byte;
      res_o.item1.last = 1'b1;
      res_o.n_items    = flush ? 2'd2 : 2'd1;
    end else begin
      res_o.item0.data = flush_byte;
      res_o.item0.last = 1'b1;
      res_o.n_items    = flush ? 2'd1 : 2'd0;
    end

    if (last_pixel_i) begin
      res_o.acc_nxt  = '0;
      res_o.pend_nxt = '0;
    end else begin
      res_o.acc_nxt  = comb_rem[AccW-1:0];
      res_o.pend_nxt = left;
    end
  end

endmodule

>>> src/grey_quantize_bit_packer.sv
// Top level of the grey-level quantiser and bit packer: APB register, packing
// state and a four-entry result queue. Depends on gqbp_pkg and gqbp_pack.
//
// Usage:
//   Pixels enter on in_valid_i / in_stall_o with pixel_i and last_pixel_i; a
//   transaction happens when valid is high and stall is low. Packed bytes
//   leave on out_valid_o / out_stall_i with packed_byte_o and last_byte_o.
//   Each pixel is quantised to bits_per_pixel bits (0 is treated as 1) and
//   appended MSB first; every full byte is emitted, and the last pixel
//   flushes a zero-padded partial byte carrying last_byte_o.
//   Bytes are registered in the queue and leave in order. One pixel per
//   cycle enters while in_stall_o is low; one byte per cycle leaves while
//   out_stall_i is low. A pixel can raise two bytes, so the four-entry
//   result queue accepts a pixel only while at least two entries are free.
//   Stalling the output fills the queue until in_stall_o rises; nothing
//   is dropped. Reset empties the queue, clears the accumulator and sets
//   bits_per_pixel to 1. The register sits at byte address 0 and should be
//   written only while the block is idle.
module grey_quantize_bit_packer import gqbp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [PixW-1:0]  pixel_i,
  input  logic             last_pixel_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PixW-1:0]  packed_byte_o,
  output logic             last_byte_o
);

  logic [BitsW-1:0] bits_q;
  logic [BitsW-1:0] bits_eff;
  logic [AccW-1:0]  acc_q;
  logic [AccW-1:0]  acc_d;
  logic [BitsW-1:0] pend_q;
  logic [BitsW-1:0] pend_d;
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [PtrW-1:0]  rd_ptr_d;
  logic [CntW-1:0]  cnt_q;
  logic [CntW-1:0]  cnt_d;
  out_item_t        fifo_q [FifoDepth];
  pack_res_t        res;
  logic             in_acc;
  logic             out_acc;
  logic             cfg_wr;
  logic [1:0]       n_push;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == RegBitsPerPixel) ? {29'd0, bits_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= BitsReset;
    end else if (cfg_wr && (paddr == RegBitsPerPixel)) begin
      bits_q <= pwdata[BitsW-1:0];
    end
  end

  assign bits_eff = (bits_q == 3'd0) ? 3'd1 : bits_q;

  gqbp_pack u_pack (
    .pixel_i      (pixel_i),
    .last_pixel_i (last_pixel_i),
    .bits_i       (bits_eff),
    .acc_i        (acc_q),
    .pend_i       (pend_q),
    .res_o        (res)
  );

  // room for two results must be there before a pixel is taken
  assign in_stall_o  = (cnt_q > CntW'(FifoDepth - 2));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign n_push      = in_acc ? res.n_items : 2'd0;

  always_comb begin
    acc_d    = acc_q;
    pend_d   = pend_q;
    wr_ptr_d = wr_ptr_q + PtrW'(n_push);
    rd_ptr_d = rd_ptr_q + PtrW'(out_acc);
    cnt_d    = cnt_q + CntW'(n_push) - CntW'(out_acc);
    if (in_acc) begin
      acc_d  = res.acc_nxt;
      pend_d = res.pend_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      pend_q   <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      acc_q    <= acc_d;
      pend_q   <= pend_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= res.item0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= res.item1;
    end
  end

  assign packed_byte_o = fifo_q[rd_ptr_q].data;
  assign last_byte_o   = fifo_q[rd_ptr_q].last;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("result queue over-filled");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CntW'(FifoDepth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with fill count");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_pixel_i) |=> (pend_q == '0 && acc_q == '0))
    else $error("accumulator not cleared after last pixel");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res.n_items != 2'd0) |=> out_valid_o)
    else $error("pushed result not presented");
`endif

endmodule
